// File: rtl/accel_tilt_angle_defines.svh
// assertion macros shared by the accel_tilt_angle checker
// expects signals named clk and arst_n in the scope of each use
`ifndef ACCEL_TILT_ANGLE_DEFINES_SVH
`define ACCEL_TILT_ANGLE_DEFINES_SVH

// checked only outside reset
`define ATILT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// checked on every edge, reset included
`define ATILT_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/atilt_pkg.sv
// shared constants, types and the arctangent table of the tilt-angle unit
// no dependencies; imported by every module of the block
`default_nettype none

package atilt_pkg;

	// sample and port geometry
	localparam int SAMPLE_WIDTH = 16;
	localparam int IN_W         = 3 * SAMPLE_WIDTH;
	localparam int ANGLE_W      = 15;
	localparam int OUT_W        = ((ANGLE_W + 7) / 8) * 8;

	// magnitude, square and sum widths
	localparam int MAG_W     = SAMPLE_WIDTH;
	localparam int SQ_W      = 2 * SAMPLE_WIDTH - 1;
	localparam int SUM_W     = 2 * SAMPLE_WIDTH;
	localparam int MSB_S_W   = $clog2(SUM_W);
	localparam int MSB_X_W   = $clog2(MAG_W);

	// normalization targets: leading one of the sum at bit 60 or 61, of |x| at bit 30
	localparam int S_TARGET_LOG = 60;
	localparam int X_TARGET_LOG = 30;
	localparam int SHIFT_W      = 5;
	localparam int K_W          = 7;

	// square root and rotation widths
	localparam int RAD_W       = 64;
	localparam int ROOT_W      = RAD_W / 2;
	localparam int NORM_X_W    = ROOT_W;
	localparam int GUARD_SHIFT = 24;
	localparam int VEC_W       = ROOT_W + GUARD_SHIFT + 3;
	localparam int ACC_W       = 32;

	// rotation steps
	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_LEN     = 32;
	localparam int NUM_STEPS    = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

	// rounding of the accumulator to whole centidegrees
	localparam int ANGLE_FRAC  = 16;
	localparam int ROUND_BIAS  = 32768;
	localparam int ANGLE_LIMIT = 9000;

	// atan(2^-i) in units of 2^-16 centidegree
	localparam logic signed [ACC_W-1:0] ATAN_TAB [ATAN_LEN] = '{
		32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
		32'sd23437865,  32'sd11730358,  32'sd5866610,  32'sd2933484,
		32'sd1466764,   32'sd733385,    32'sd366693,   32'sd183346,
		32'sd91673,     32'sd45837,     32'sd22918,    32'sd11459,
		32'sd5730,      32'sd2865,      32'sd1432,     32'sd716,
		32'sd358,       32'sd179,       32'sd90,       32'sd45,
		32'sd22,        32'sd11,        32'sd6,        32'sd3,
		32'sd1,         32'sd1,         32'sd0,        32'sd0
	};

	// flags that travel with an item through the pipeline
	typedef struct packed {
		logic xneg;
		logic xzero;
		logic szero;
	} meta_t;

	// sideband that rides along the square root
	typedef struct packed {
		meta_t                meta;
		logic [NORM_X_W-1:0]  ax;
	} side_t;

endpackage

`default_nettype wire

// File: rtl/accel_tilt_angle.sv
// top level of the accelerometer tilt-angle unit
// depends on atilt_pkg, atilt_isqrt and atilt_cordic
//
// Usage:
//   s_* channel takes one sample per item: x, y, z as signed 16-bit counts.
//   m_* channel gives one result per item: the tilt angle
//   atan(x / sqrt(y^2 + z^2)) in hundredths of a degree (-9000..9000) in
//   m_tdata, and m_tuser set when all three axes are zero (angle then 0).
//   If y and z are zero and x is not, the angle is +/-9000 by the sign of x.
// Pipeline: from the accepting edge to m_tvalid lie five front stages
//   (magnitudes, squares, sum, shift count, normalize), sixteen square-root
//   stages, one load and sixteen rotation stages, one rounding stage and
//   the output register.
// Throughput: one item per cycle while s_tready is high; every stage is a
//   register and samples do not depend on each other.
// Stall: the whole pipeline advances on one enable; a held m_tready parks
//   one item in the output register and one in a skid register, then
//   s_tready drops (registered) until the skid register drains.
// Reset: arst_n clears all valid bits; no item is lost or repeated after it.
`default_nettype none

module accel_tilt_angle
	import atilt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [IN_W-1:0]   s_tdata,   // accel_x, accel_y, accel_z
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OUT_W-1:0]       m_tdata,   // angle_centideg, zero pad
	output logic [0:0]             m_tuser    // angle_invalid
);

	logic en;
	logic in_fire;

	// stage 1: magnitudes
	logic [MAG_W-1:0] x_raw, y_raw, z_raw;
	logic [MAG_W-1:0] ax_s1, ay_s1, az_s1;
	logic             xneg_s1, xzero_s1, valid_s1;

	// stage 2: squares
	logic [2*MAG_W-1:0] ay_prod, az_prod;
	logic [SQ_W-1:0]    ay2_s2, az2_s2;
	logic [MAG_W-1:0]   ax_s2;
	logic               xneg_s2, xzero_s2, valid_s2;

	// stage 3: sum of squares
	logic [SUM_W-1:0] sum_s3;
	logic [MAG_W-1:0] ax_s3;
	logic             xneg_s3, xzero_s3, valid_s3;

	// stage 4: common shift count
	logic [MSB_S_W-1:0] msb_s;
	logic [MSB_X_W-1:0] msb_x;
	logic [K_W-1:0]     ks, kx, k_min;
	logic [SHIFT_W-1:0] k_s4;
	logic [SUM_W-1:0]   sum_s4;
	logic [MAG_W-1:0]   ax_s4;
	meta_t              meta_s4;
	logic               valid_s4;

	// stage 5: normalized pair
	logic [RAD_W-1:0]   rad_s5;
	side_t              side_s5;
	logic               valid_s5;

	// square root and rotation
	logic                    sq_valid;
	logic [ROOT_W-1:0]       sq_root;
	side_t                   sq_side;
	logic                    cd_valid;
	logic signed [ACC_W-1:0] cd_acc;
	meta_t                   cd_meta;

	// rounding stage
	logic signed [ACC_W-1:0]            acc_rnd;
	logic signed [ACC_W-ANGLE_FRAC-1:0] ang_whole;
	logic [ANGLE_W-1:0]                 ang_nxt;
	logic                               inv_nxt;
	logic [ANGLE_W-1:0]                 angle_s6;
	logic                               inv_s6, valid_s6;

	// output register and skid register
	logic               out_valid_q, skid_valid_q;
	logic [ANGLE_W-1:0] out_angle_q, skid_angle_q;
	logic               out_inv_q, skid_inv_q;
	logic               take, arrive;

	// the pipeline moves as long as the skid register is empty
	assign en       = ~skid_valid_q;
	assign s_tready = en;
	assign in_fire  = s_tvalid & en;

	assign x_raw = s_tdata[MAG_W-1:0];
	assign y_raw = s_tdata[2*MAG_W-1:MAG_W];
	assign z_raw = s_tdata[3*MAG_W-1:2*MAG_W];

	assign ay_prod = ay_s1 * ay_s1;
	assign az_prod = az_s1 * az_s1;

	// leading-one positions and the shift count min(ks, kx)
	always_comb begin
		msb_s = '0;
		for (int b = 0; b < SUM_W; b++) begin
			if (sum_s3[b]) begin
				msb_s = MSB_S_W'(b);
			end
		end
		msb_x = '0;
		for (int b = 0; b < MAG_W; b++) begin
			if (ax_s3[b]) begin
				msb_x = MSB_X_W'(b);
			end
		end
		if (K_W'(msb_s) >= K_W'(S_TARGET_LOG)) begin
			ks = '0;
		end else begin
			ks = (K_W'(S_TARGET_LOG + 1) - K_W'(msb_s)) >> 1;
		end
		if (ax_s3 == '0) begin
			kx = '1;
		end else if (K_W'(msb_x) >= K_W'(X_TARGET_LOG)) begin
			kx = '0;
		end else begin
			kx = K_W'(X_TARGET_LOG) - K_W'(msb_x);
		end
		k_min = (ks < kx) ? ks : kx;
	end

	// front valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_fire;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// front payload
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1    <= x_raw[MAG_W-1] ? (~x_raw + 1'b1) : x_raw;
			ay_s1    <= y_raw[MAG_W-1] ? (~y_raw + 1'b1) : y_raw;
			az_s1    <= z_raw[MAG_W-1] ? (~z_raw + 1'b1) : z_raw;
			xneg_s1  <= x_raw[MAG_W-1];
			xzero_s1 <= (x_raw == '0);

			ay2_s2   <= ay_prod[SQ_W-1:0];
			az2_s2   <= az_prod[SQ_W-1:0];
			ax_s2    <= ax_s1;
			xneg_s2  <= xneg_s1;
			xzero_s2 <= xzero_s1;

			sum_s3   <= SUM_W'(ay2_s2) + SUM_W'(az2_s2);
			ax_s3    <= ax_s2;
			xneg_s3  <= xneg_s2;
			xzero_s3 <= xzero_s2;

			k_s4          <= k_min[SHIFT_W-1:0];
			sum_s4        <= sum_s3;
			ax_s4         <= ax_s3;
			meta_s4.xneg  <= xneg_s3;
			meta_s4.xzero <= xzero_s3;
			meta_s4.szero <= (sum_s3 == '0);

			rad_s5       <= RAD_W'(sum_s4) << {k_s4, 1'b0};
			side_s5.ax   <= NORM_X_W'(ax_s4) << k_s4;
			side_s5.meta <= meta_s4;
		end
	end

	atilt_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s5),
		.in_rad    (rad_s5),
		.in_side   (side_s5),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	atilt_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.in_root   (sq_root),
		.in_side   (sq_side),
		.out_valid (cd_valid),
		.out_acc   (cd_acc),
		.out_meta  (cd_meta)
	);

	// round half up, clamp, and the zero-magnitude cases
	always_comb begin
		acc_rnd   = cd_acc + ACC_W'(ROUND_BIAS);
		ang_whole = acc_rnd[ACC_W-1:ANGLE_FRAC];
		inv_nxt   = 1'b0;
		if (cd_meta.szero) begin
			if (cd_meta.xzero) begin
				ang_nxt = '0;
				inv_nxt = 1'b1;
			end else if (cd_meta.xneg) begin
				ang_nxt = ANGLE_W'(-ANGLE_LIMIT);
			end else begin
				ang_nxt = ANGLE_W'(ANGLE_LIMIT);
			end
		end else if (ang_whole > ANGLE_LIMIT) begin
			ang_nxt = ANGLE_W'(ANGLE_LIMIT);
		end else if (ang_whole < -ANGLE_LIMIT) begin
			ang_nxt = ANGLE_W'(-ANGLE_LIMIT);
		end else begin
			ang_nxt = ang_whole[ANGLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= cd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_s6 <= ang_nxt;
			inv_s6   <= inv_nxt;
		end
	end

	// output register with one skid entry behind it
	assign take   = out_valid_q & m_tready;
	assign arrive = en & valid_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || take) begin
			out_valid_q <= arrive;
		end else if (arrive) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_angle_q <= skid_angle_q;
				out_inv_q   <= skid_inv_q;
			end
		end else if (!out_valid_q || take) begin
			out_angle_q <= angle_s6;
			out_inv_q   <= inv_s6;
		end else begin
			skid_angle_q <= angle_s6;
			skid_inv_q   <= inv_s6;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W-ANGLE_W){1'b0}}, out_angle_q};
	assign m_tuser  = out_inv_q;

endmodule

`default_nettype wire

// File: rtl/atilt_isqrt.sv
// pipelined floor square root of a 64-bit radicand, two result bits per stage
// depends on atilt_pkg; sideband and valid travel with the data
`default_nettype none

module atilt_isqrt
	import atilt_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire logic [RAD_W-1:0]   in_rad,
	input  wire side_t              in_side,
	output logic                    out_valid,
	output logic [ROOT_W-1:0]       out_root,
	output side_t                   out_side
);

	localparam int PER_STAGE = 2;
	localparam int STAGES    = ROOT_W / PER_STAGE;
	localparam int REM_W     = ROOT_W + 2;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	// one restoring digit step: bring down two bits, try to subtract
	function automatic sq_t sqrt_step(input sq_t a);
		sq_t              r;
		logic [REM_W-1:0] rem_n;
		logic [REM_W-1:0] trial;
		rem_n = {a.rem[REM_W-3:0], a.rad[RAD_W-1 -: 2]};
		trial = {a.root, 2'b01};
		r.rad = a.rad << 2;
		if (rem_n >= trial) begin
			r.rem  = rem_n - trial;
			r.root = {a.root[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem  = rem_n;
			r.root = {a.root[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	sq_t   st_s    [STAGES];
	side_t side_s  [STAGES];
	logic  valid_s [STAGES];
	sq_t   st_in   [STAGES];
	sq_t   st_nxt  [STAGES];

	// stage inputs and digit steps
	always_comb begin
		st_in[0] = '{rad: in_rad, rem: '0, root: '0};
		for (int g = 1; g < STAGES; g++) begin
			st_in[g] = st_s[g-1];
		end
		for (int g = 0; g < STAGES; g++) begin
			st_nxt[g] = st_in[g];
			for (int j = 0; j < PER_STAGE; j++) begin
				st_nxt[g] = sqrt_step(st_nxt[g]);
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < STAGES; g++) begin
				valid_s[g] <= 1'b0;
			end
		end else if (en) begin
			valid_s[0] <= in_valid;
			for (int g = 1; g < STAGES; g++) begin
				valid_s[g] <= valid_s[g-1];
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			for (int g = 1; g < STAGES; g++) begin
				side_s[g] <= side_s[g-1];
			end
			for (int g = 0; g < STAGES; g++) begin
				st_s[g] <= st_nxt[g];
			end
		end
	end

	assign out_valid = valid_s[STAGES-1];
	assign out_root  = st_s[STAGES-1].root;
	assign out_side  = side_s[STAGES-1];

endmodule

`default_nettype wire

// File: rtl/atilt_cordic.sv
// pipelined cordic vectoring, one rotation per stage, angle accumulated per step
// depends on atilt_pkg for widths and the arctangent table
`default_nettype none

module atilt_cordic
	import atilt_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    in_valid,
	input  wire logic [ROOT_W-1:0]       in_root,
	input  wire side_t                   in_side,
	output logic                         out_valid,
	output logic signed [ACC_W-1:0]      out_acc,
	output meta_t                        out_meta
);

	typedef struct packed {
		logic signed [VEC_W-1:0] vx;
		logic signed [VEC_W-1:0] vy;
		logic signed [ACC_W-1:0] acc;
	} rot_t;

	rot_t  ld_s;
	meta_t ld_meta_s;
	logic  ld_valid_s;

	rot_t  rot_s   [NUM_STEPS];
	meta_t meta_s  [NUM_STEPS];
	logic  valid_s [NUM_STEPS];
	rot_t  rot_in  [NUM_STEPS];
	rot_t  rot_nxt [NUM_STEPS];

	logic [VEC_W-1:0] vy_mag;
	rot_t             ld_nxt;

	// starting vector: (root, +/-|x|) scaled by the guard bits
	always_comb begin
		vy_mag        = VEC_W'(in_side.ax) << GUARD_SHIFT;
		ld_nxt.vx     = $signed(VEC_W'(in_root) << GUARD_SHIFT);
		ld_nxt.vy     = in_side.meta.xneg ? $signed(-vy_mag) : $signed(vy_mag);
		ld_nxt.acc    = '0;
	end

	// rotation steps, residual of zero counts as non-negative
	always_comb begin
		logic signed [VEC_W-1:0] dx;
		logic signed [VEC_W-1:0] dy;
		rot_in[0] = ld_s;
		for (int i = 1; i < NUM_STEPS; i++) begin
			rot_in[i] = rot_s[i-1];
		end
		for (int i = 0; i < NUM_STEPS; i++) begin
			dx = $signed(rot_in[i].vy) >>> i;
			dy = $signed(rot_in[i].vx) >>> i;
			if (!rot_in[i].vy[VEC_W-1]) begin
				rot_nxt[i].vx  = rot_in[i].vx + dx;
				rot_nxt[i].vy  = rot_in[i].vy - dy;
				rot_nxt[i].acc = rot_in[i].acc + ATAN_TAB[i];
			end else begin
				rot_nxt[i].vx  = rot_in[i].vx - dx;
				rot_nxt[i].vy  = rot_in[i].vy + dy;
				rot_nxt[i].acc = rot_in[i].acc - ATAN_TAB[i];
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_valid_s <= 1'b0;
			for (int i = 0; i < NUM_STEPS; i++) begin
				valid_s[i] <= 1'b0;
			end
		end else if (en) begin
			ld_valid_s <= in_valid;
			valid_s[0] <= ld_valid_s;
			for (int i = 1; i < NUM_STEPS; i++) begin
				valid_s[i] <= valid_s[i-1];
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			ld_s      <= ld_nxt;
			ld_meta_s <= in_side.meta;
			meta_s[0] <= ld_meta_s;
			for (int i = 1; i < NUM_STEPS; i++) begin
				meta_s[i] <= meta_s[i-1];
			end
			for (int i = 0; i < NUM_STEPS; i++) begin
				rot_s[i] <= rot_nxt[i];
			end
		end
	end

	assign out_valid = valid_s[NUM_STEPS-1];
	assign out_acc   = rot_s[NUM_STEPS-1].acc;
	assign out_meta  = meta_s[NUM_STEPS-1];

endmodule

`default_nettype wire

// File: rtl/atilt_checker.sv
// port-level checks of the tilt-angle unit, bound to the top level
// depends on atilt_pkg and accel_tilt_angle_defines.svh
`default_nettype none
`include "accel_tilt_angle_defines.svh"

module atilt_checker
	import atilt_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tready,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata,
	input wire logic [0:0]       m_tuser
);

	// angle field, its range with a clear pad bit, and the whole result item
	logic signed [ANGLE_W-1:0] angle;
	logic                      angle_ok;
	logic [OUT_W:0]            result;

	assign angle    = m_tdata[ANGLE_W-1:0];
	assign angle_ok = (angle <= ANGLE_LIMIT) && (angle >= -ANGLE_LIMIT) && !m_tdata[OUT_W-1];
	assign result   = {m_tuser, m_tdata};

	// a stalled result item holds
	`ATILT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(result), "stall not held")

	// input side only closes while a result waits
	`ATILT_ASSERT_ALWAYS(a_ready_backs, !s_tready |-> m_tvalid, "input blocked with no result waiting")

	// invalid flag goes with a zero angle
	`ATILT_ASSERT(a_invalid_zero, m_tvalid && m_tuser[0] |-> angle == '0, "invalid with nonzero angle")

	// angle stays within a quarter turn and the pad bit is clear
	`ATILT_ASSERT(a_angle_range, m_tvalid |-> angle_ok, "angle out of range")

endmodule

bind accel_tilt_angle atilt_checker u_atilt_checker (.*);

`default_nettype wire
